// File: sv/hbr_pkg.sv
// ---------------------------------------------------------------------------
// hbr_pkg
// Shared types, codes and defaults of the node heartbeat registry.
// ---------------------------------------------------------------------------
package hbr_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int PAW = 3;

	localparam logic [15:0] EMPTY_ID = 16'hFFFF;
	localparam logic [31:0] TIMEOUT_RST = 32'd1000;

	localparam logic [PAW-3:0] REG_TIMEOUT = '0;

	localparam logic [1:0] OP_HEARTBEAT = 2'd0;
	localparam logic [1:0] OP_ANNOUNCE  = 2'd1;
	localparam logic [1:0] OP_SWEEP     = 2'd2;
	localparam logic [1:0] OP_RESERVED  = 2'd3;

	localparam logic [2:0] STS_REFRESHED = 3'd0;
	localparam logic [2:0] STS_ADDED     = 3'd1;
	localparam logic [2:0] STS_KNOWN     = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_IGNORED   = 3'd4;
	localparam logic [2:0] STS_SWEPT     = 3'd5;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] node_id;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [3:0]  slot;
		logic        node_online;
		logic [4:0]  registered_count;
		logic        offline_present;
		logic [15:0] offline_id;
		logic [4:0]  went_offline;
	} out_item_t;

	typedef struct packed {
		logic [31:0] timeout_ms;
	} cfg_t;

endpackage

// File: sv/hbr_in_if.sv
// ---------------------------------------------------------------------------
// hbr_in_if
// Request channel: valid/ready handshake with one input item.
// ---------------------------------------------------------------------------
interface hbr_in_if;
	logic              valid;
	logic              ready;
	hbr_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/hbr_out_if.sv
// ---------------------------------------------------------------------------
// hbr_out_if
// Response channel: valid/ready handshake with one result item.
// ---------------------------------------------------------------------------
interface hbr_out_if;
	logic               valid;
	logic               ready;
	hbr_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/hbr_ram.sv
// ---------------------------------------------------------------------------
// hbr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/hbr_apb.sv
// ---------------------------------------------------------------------------
// hbr_apb
// APB register file: timeout register.
// ---------------------------------------------------------------------------
module hbr_apb (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [hbr_pkg::PAW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output hbr_pkg::cfg_t           cfg
);

	logic          hit;
	hbr_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign hit    = (paddr[hbr_pkg::PAW-1:2] == hbr_pkg::REG_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms <= hbr_pkg::TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && hit) begin
			cfg_q.timeout_ms <= pwdata;
		end
	end

	assign prdata = hit ? cfg_q.timeout_ms : '0;
	assign cfg    = cfg_q;

endmodule

// File: sv/hbr_core.sv
// ---------------------------------------------------------------------------
// hbr_core
// Slot table engine: scans the slot memory once per item, then applies
// the update and registers the result.
// ---------------------------------------------------------------------------
module hbr_core #(
	parameter int SLOTS = hbr_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hbr_pkg::cfg_t cfg,
	hbr_in_if.sink        req,
	hbr_out_if.source     rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int MW = 48;
	localparam logic [CW-1:0] NSLOT = CW'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      rd_cnt_q;
	logic               dv_s1;
	logic [IW-1:0]      idx_s1;
	logic [SLOTS-1:0]   valid_q;
	logic [SLOTS-1:0]   online_q;

	logic [1:0]         op_q;
	logic [15:0]        id_q;
	logic [31:0]        now_q;
	logic               match_q;
	logic [IW-1:0]      match_idx_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      went_q;
	logic               off1_q;
	logic [IW-1:0]      off1_idx_q;
	logic [15:0]        off1_id_q;
	logic               off2_q;
	logic [15:0]        off2_id_q;

	logic               rsp_valid_q;
	hbr_pkg::out_item_t rsp_data_q;

	logic               accept;
	logic               rd_en;
	logic [MW-1:0]      rd_data;
	logic [15:0]        rd_id;
	logic [31:0]        rd_ts;
	logic               sc_valid;
	logic               sc_hit;
	logic               sc_expire;
	logic               sc_off;

	logic               is_sweep;
	logic               is_empty;
	logic               do_refresh;
	logic               do_place;
	logic               go;
	logic               wr_en;
	logic [IW-1:0]      wr_idx;
	hbr_pkg::out_item_t res;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rd_en    = (state_q == ST_SCAN) && (rd_cnt_q < NSLOT);

	hbr_ram #(
		.WIDTH (MW),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata ({id_q, now_q}),
		.re    (rd_en),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (rd_data)
	);

	// scan stage: one slot per cycle
	always_comb begin
		logic [31:0] age;
		logic        on;
		rd_id     = rd_data[MW-1:32];
		rd_ts     = rd_data[31:0];
		age       = now_q - rd_ts;
		on        = online_q[idx_s1];
		sc_valid  = dv_s1 && valid_q[idx_s1];
		sc_hit    = sc_valid && (rd_id == id_q) && (id_q != hbr_pkg::EMPTY_ID);
		sc_expire = sc_valid && is_sweep && on && (age > cfg.timeout_ms);
		sc_off    = sc_valid && !(on && !sc_expire);
	end

	assign is_sweep   = (op_q == hbr_pkg::OP_SWEEP) || (op_q == hbr_pkg::OP_RESERVED);
	assign is_empty   = (id_q == hbr_pkg::EMPTY_ID);
	assign do_refresh = !is_sweep && !is_empty && match_q && (op_q == hbr_pkg::OP_HEARTBEAT);
	assign do_place   = !is_sweep && !is_empty && !match_q && free_q;
	assign go         = !rsp_valid_q || rsp.ready;
	assign wr_en      = (state_q == ST_APPLY) && go && (do_refresh || do_place);
	assign wr_idx     = match_q ? match_idx_q : free_idx_q;

	// result after the update
	always_comb begin
		logic [CW-1:0] cnt;
		logic          use2;
		cnt  = cnt_q + CW'(do_place);
		use2 = do_refresh && (off1_idx_q == match_idx_q);
		res  = '0;
		if (is_sweep) begin
			res.status = hbr_pkg::STS_SWEPT;
		end else if (is_empty) begin
			res.status = hbr_pkg::STS_IGNORED;
		end else if (match_q) begin
			res.status = (op_q == hbr_pkg::OP_HEARTBEAT) ? hbr_pkg::STS_REFRESHED
				: hbr_pkg::STS_KNOWN;
		end else if (free_q) begin
			res.status = hbr_pkg::STS_ADDED;
		end else begin
			res.status = hbr_pkg::STS_FULL;
		end
		res.found            = match_q || do_place;
		res.slot             = res.found ? 4'(wr_idx) : 4'd0;
		res.node_online      = do_refresh || do_place || (match_q && online_q[match_idx_q]);
		res.registered_count = 5'(cnt);
		res.went_offline     = is_sweep ? 5'(went_q) : 5'd0;
		if (off1_q && !use2) begin
			res.offline_present = 1'b1;
			res.offline_id      = off1_id_q;
		end else if (use2 && off2_q) begin
			res.offline_present = 1'b1;
			res.offline_id      = off2_id_q;
		end else begin
			res.offline_present = 1'b0;
			res.offline_id      = hbr_pkg::EMPTY_ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			dv_s1       <= 1'b0;
			valid_q     <= '0;
			online_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			dv_s1 <= rd_en;
			if ((state_q == ST_APPLY) && go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (sc_expire) begin
						online_q[idx_s1] <= 1'b0;
					end
					if (rd_cnt_q == NSLOT) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (go) begin
						if (do_refresh || do_place) begin
							online_q[wr_idx] <= 1'b1;
						end
						if (do_place) begin
							valid_q[wr_idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IW-1:0];
		if (accept) begin
			op_q    <= req.data.opcode;
			id_q    <= req.data.node_id;
			now_q   <= req.data.now_ms;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			cnt_q   <= '0;
			went_q  <= '0;
			off1_q  <= 1'b0;
			off2_q  <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (sc_hit && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= idx_s1;
			end
			if (dv_s1 && !valid_q[idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (sc_valid) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (sc_expire) begin
				went_q <= went_q + CW'(1);
			end
			if (sc_off) begin
				if (!off1_q) begin
					off1_q     <= 1'b1;
					off1_idx_q <= idx_s1;
					off1_id_q  <= rd_id;
				end else if (!off2_q) begin
					off2_q    <= 1'b1;
					off2_id_q <= rd_id;
				end
			end
		end
		if ((state_q == ST_APPLY) && go) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef ASSERT_OFF
	a_online_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(online_q & ~valid_q) == '0)
		else $error("online mark on an empty slot");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= NSLOT)
		else $error("scan counter past last slot");

	a_went_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_data_q.went_offline <= rsp_data_q.registered_count))
		else $error("more nodes went offline than are registered");

	a_online_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.node_online |-> rsp_data_q.found)
		else $error("online reported for a node not in the table");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr_en)
		else $error("slot memory written during scan");
`endif

endmodule

// File: sv/node_heartbeat_registry_unit.sv
// ---------------------------------------------------------------------------
// node_heartbeat_registry_unit
// Liveness table of remote nodes with heartbeat, announce and timeout sweep.
// ---------------------------------------------------------------------------
// One item is handled at a time: the request transfer takes place in the idle
// state, the scan state reads the slot memory through its single read port
// (one slot per cycle, with registered read data), and the apply state writes
// back the touched slot and registers the result, after which the block
// returns to idle and can take the next request.
// A new request is taken
// while the previous result still waits on the response channel; its
// write-back cycle then stalls until that result is taken. Slot occupancy and
// online marks live in flip-flops that reset clears, so the table is usable
// right after reset with no clearing pass.
// The timeout register sits at byte address 0 of the APB port.
module node_heartbeat_registry_unit #(
	parameter int SLOTS = hbr_pkg::SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	hbr_in_if.sink                  req,
	hbr_out_if.source               rsp,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [hbr_pkg::PAW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	hbr_pkg::cfg_t cfg;

	hbr_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hbr_core #(
		.SLOTS (SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
